// ===== sv/bpc_pkg.sv =====
// ============================================================================
// bpc_pkg: shared types and constants
// Constants, configuration register indices and divider request and response types of the pressure compensation.
// ============================================================================
package bpc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_AC123 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC456 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B12   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MCMD  = 2'd3;

    localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
    localparam logic [31:0]        B4_BIAS   = 32'd32768;
    localparam logic [31:0]        B7_SCALE  = 32'd50000;
    localparam logic signed [31:0] P_C1      = 32'sd3038;
    localparam logic signed [31:0] P_C2      = -32'sd7357;
    localparam logic signed [31:0] P_C3      = 32'sd3791;
    localparam logic signed [31:0] OUT_MAX   = 32'sd1048575;
    localparam logic signed [31:0] OUT_MIN   = -32'sd1048576;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/bpc_div.sv =====
// ============================================================================
// bpc_div: unsigned 32-bit divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module bpc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bpc_pkg::div_req_t req,
    output bpc_pkg::div_rsp_t rsp
);
    import bpc_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, den_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== sv/barometric_pressure_compensation_top.sv =====
// ============================================================================
// barometric_pressure_compensation_top: sensor compensation
// Datasheet temperature and pressure compensation on a shared multiplier.
// ============================================================================
// One item is taken at a time. Each item keeps the input busy while it runs
// through its steps on the single 32x32 multiplier and its wait on the
// bit-serial divider; a zero divisor ends a temperature or a pressure item
// before the divide. The result moves into an output register and is held
// there until taken; the next item is accepted meanwhile, but its result waits
// until the output register is free.
module barometric_pressure_compensation_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic [15:0]                      s_raw_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_result_kind,
    output logic signed [20:0]               m_result_value,
    output logic                             m_div_error
);
    import bpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_T_MUL, S_T_DEN, S_T_DIV, S_T_WAIT, S_T_FIN,
        S_P_SQ, S_P_M1, S_P_M2, S_P_M3, S_P_M4, S_P_B3, S_P_B4, S_P_B7,
        S_P_DIV, S_P_WAIT, S_P_Q, S_P_F1, S_P_F2, S_P_F3, S_P_FIN, S_OUT
    } state_t;

    logic [47:0] ac123_reg, ac456_reg;
    logic [31:0] b12_reg, mcmd_reg;
    logic signed [31:0] b5_reg;

    state_t state_reg;
    logic        func_reg;
    logic [15:0] raw_reg;
    logic signed [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic        neg_reg;
    logic        div_split_reg;
    logic        m_valid_reg;
    logic        kind_reg;
    logic signed [20:0] value_reg;
    logic        err_reg;
    logic signed [20:0] out_value_reg;
    logic        out_err_reg;

    logic signed [31:0] mul_a, mul_b, mul_p;
    logic signed [63:0] mul_full;
    div_req_t dreq;
    div_rsp_t drsp;

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0] ac4, ac5, ac6;

    assign ac1 = 32'(signed'(ac123_reg[47:32]));
    assign ac2 = 32'(signed'(ac123_reg[31:16]));
    assign ac3 = 32'(signed'(ac123_reg[15:0]));
    assign ac4 = {16'd0, ac456_reg[47:32]};
    assign ac5 = {16'd0, ac456_reg[31:16]};
    assign ac6 = {16'd0, ac456_reg[15:0]};
    assign b1  = 32'(signed'(b12_reg[31:16]));
    assign b2  = 32'(signed'(b12_reg[15:0]));
    assign mc  = 32'(signed'(mcmd_reg[31:16]));
    assign md  = 32'(signed'(mcmd_reg[15:0]));

    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[31:0];

    bpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    function automatic logic signed [20:0] sat21(input logic signed [31:0] v);
        if (v > OUT_MAX) return OUT_MAX[20:0];
        if (v < OUT_MIN) return OUT_MIN[20:0];
        return v[20:0];
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    logic signed [31:0] b6;
    logic signed [31:0] pd8;
    assign b6   = b5_reg - B6_OFFSET;
    assign pd8  = e_reg >>> 8;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        dreq  = '0;
        case (state_reg)
            S_T_MUL: begin
                mul_a = 32'({16'd0, raw_reg}) - ac6;
                mul_b = ac5;
            end
            S_T_DEN: begin
                mul_a = mc;
                mul_b = 32'sd2048;
            end
            S_T_DIV: begin
                dreq.start    = 1'b1;
                dreq.dividend = abs32(b_reg);
                dreq.divisor  = abs32(a_reg + md);
            end
            S_P_SQ: begin
                mul_a = b6;
                mul_b = b6;
            end
            S_P_M1: begin
                mul_a = b2;
                mul_b = a_reg;
            end
            S_P_M2: begin
                mul_a = ac2;
                mul_b = b6;
            end
            S_P_M3: begin
                mul_a = ac3;
                mul_b = b6;
            end
            S_P_M4: begin
                mul_a = b1;
                mul_b = a_reg;
            end
            S_P_B4: begin
                mul_a = ac4;
                mul_b = d_reg + B4_BIAS;
            end
            S_P_B7: begin
                mul_a = 32'({16'd0, raw_reg}) - c_reg;
                mul_b = B7_SCALE;
            end
            S_P_DIV: begin
                dreq.start    = 1'b1;
                dreq.dividend = b_reg[31] ? b_reg : (b_reg << 1);
                dreq.divisor  = d_reg;
            end
            S_P_F1: begin
                mul_a = pd8;
                mul_b = pd8;
            end
            S_P_F2: begin
                mul_a = a_reg;
                mul_b = P_C1;
            end
            S_P_F3: begin
                mul_a = P_C2;
                mul_b = e_reg;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac123_reg   <= '0;
            ac456_reg   <= '0;
            b12_reg     <= '0;
            mcmd_reg    <= '0;
            b5_reg      <= '0;
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_AC123: ac123_reg <= cfg_data;
                    REG_AC456: ac456_reg <= cfg_data;
                    REG_B12:   b12_reg   <= cfg_data[31:0];
                    REG_MCMD:  mcmd_reg  <= cfg_data[31:0];
                    default:   ac123_reg <= ac123_reg;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        func_reg  <= s_func;
                        raw_reg   <= s_raw_sample;
                        state_reg <= s_func ? S_P_SQ : S_T_MUL;
                    end
                end
                S_T_MUL: begin
                    a_reg     <= mul_p >>> 15;
                    state_reg <= S_T_DEN;
                end
                S_T_DEN: begin
                    b_reg <= mul_p;
                    if (a_reg + md == 32'sd0) begin
                        err_reg   <= 1'b1;
                        value_reg <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_T_DIV;
                    end
                end
                S_T_DIV: begin
                    neg_reg   <= b_reg[31] ^ (a_reg + md < 0);
                    state_reg <= S_T_WAIT;
                end
                S_T_WAIT: begin
                    if (drsp.done) begin
                        c_reg     <= neg_reg ? 32'(-drsp.quotient) : drsp.quotient;
                        state_reg <= S_T_FIN;
                    end
                end
                S_T_FIN: begin
                    b5_reg    <= a_reg + c_reg;
                    err_reg   <= 1'b0;
                    value_reg <= sat21((a_reg + c_reg + 32'sd8) >>> 4);
                    state_reg <= S_OUT;
                end
                S_P_SQ: begin
                    a_reg     <= mul_p >>> 12;
                    state_reg <= S_P_M1;
                end
                S_P_M1: begin
                    b_reg     <= mul_p >>> 11;
                    state_reg <= S_P_M2;
                end
                S_P_M2: begin
                    b_reg     <= b_reg + (mul_p >>> 11);
                    state_reg <= S_P_M3;
                end
                S_P_M3: begin
                    c_reg     <= mul_p >>> 13;
                    state_reg <= S_P_M4;
                end
                S_P_M4: begin
                    d_reg     <= (c_reg + (mul_p >>> 16) + 32'sd2) >>> 2;
                    c_reg     <= ac1 * 32'sd4 + b_reg + 32'sd2;
                    state_reg <= S_P_B3;
                end
                S_P_B3: begin
                    c_reg     <= (c_reg < 0) ? -((-c_reg) >> 2) : (c_reg >>> 2);
                    state_reg <= S_P_B4;
                end
                S_P_B4: begin
                    d_reg     <= 32'(mul_p) >> 15;
                    state_reg <= S_P_B7;
                end
                S_P_B7: begin
                    b_reg <= mul_p;
                    if (d_reg == 32'd0) begin
                        err_reg   <= 1'b1;
                        value_reg <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_P_DIV;
                    end
                end
                S_P_DIV: begin
                    div_split_reg <= b_reg[31];
                    state_reg     <= S_P_WAIT;
                end
                S_P_WAIT: begin
                    if (drsp.done) begin
                        e_reg     <= div_split_reg ? (drsp.quotient << 1) : drsp.quotient;
                        state_reg <= S_P_F1;
                    end
                end
                S_P_F1: begin
                    a_reg     <= mul_p;
                    state_reg <= S_P_F2;
                end
                S_P_F2: begin
                    a_reg     <= mul_p >>> 16;
                    state_reg <= S_P_F3;
                end
                S_P_F3: begin
                    b_reg     <= mul_p >>> 16;
                    state_reg <= S_P_FIN;
                end
                S_P_FIN: begin
                    err_reg   <= 1'b0;
                    value_reg <= sat21(e_reg + ((a_reg + b_reg + P_C3) >>> 4));
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        kind_reg      <= func_reg;
                        out_value_reg <= value_reg;
                        out_err_reg   <= err_reg;
                        m_valid_reg   <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_result_value = out_value_reg;
    assign m_div_error    = out_err_reg;

endmodule
